### hdl/lfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfw_pkg: shared types and constants for the LED driver frame writer
// Payload structs for both channels, the internal command queue entry and
// the fixed command bytes of a frame.
// ----------------------------------------------------------------------------
package lfw_pkg;

	localparam int DIGIT_INPUTS      = 5;
	localparam int DIGIT_COUNT_DEF   = 5;
	localparam int DIGIT_IDX_W       = $clog2(DIGIT_INPUTS);
	localparam int SEG_W             = 5;
	localparam int QUEUE_DEPTH       = 2;
	localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CMD_DATA       = 8'h40;
	localparam logic [7:0] CMD_ADDR       = 8'hC0;
	localparam logic [7:0] CMD_DISP_RESET = 8'h8C;
	localparam logic [7:0] LSB_MASK       = 8'h01;

	localparam logic ACTION_TICK  = 1'b0;
	localparam logic ACTION_START = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] digit0;
		logic [7:0] digit1;
		logic [7:0] digit2;
		logic [7:0] digit3;
		logic [7:0] digit4;
	} item_t;

	typedef struct packed {
		logic clock_pin;
		logic data_pin;
		logic data_drive;
		logic busy_res;
		logic frame_done;
	} result_t;

	typedef struct packed {
		logic                             is_start;
		logic [DIGIT_INPUTS-1:0][7:0]     digits;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

### hdl/led_driver_frame_writer.sv
`timescale 1ns / 1ps
// Path: an accepted item is written to the queue, then to the sequencer's
// output register, which raises result_valid.
// Throughput: one item per cycle while result_stall is low.
// Reset: arst_n clears the queue, the sequencer (idle, both lines high) and
// sets the display command to 0x8C; the digit store is not reset.
// ----------------------------------------------------------------------------
// led_driver_frame_writer: two-wire LED driver frame writer
// Front queue of start and tick commands feeding a pin-step sequencer that
// sends data, address with digits, and display command bytes LSB first.
// ----------------------------------------------------------------------------
module led_driver_frame_writer #(
	parameter int DIGIT_COUNT = lfw_pkg::DIGIT_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  lfw_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output lfw_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);

	lfw_pkg::qhead_t head;
	logic            pop;

	assign cfg_ready = 1'b1;

	lfw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.head       (head),
		.pop        (pop)
	);

	lfw_back #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### hdl/lfw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfw_front: input side of the frame writer
// Takes input transfers, sorts them into start and tick commands and holds
// them in a short queue for the sequencer.
// ----------------------------------------------------------------------------
module lfw_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  lfw_pkg::item_t item,
	output lfw_pkg::qhead_t head,
	input  logic           pop
);

	lfw_pkg::cmd_t                         entry_q [lfw_pkg::QUEUE_DEPTH];
	logic [lfw_pkg::QUEUE_PTR_W-1:0]       wr_ptr_q;
	logic [lfw_pkg::QUEUE_PTR_W-1:0]       rd_ptr_q;
	logic [lfw_pkg::QUEUE_CNT_W-1:0]       count_q;
	logic                                  push;
	logic                                  do_pop;
	lfw_pkg::cmd_t                         cmd_in;

	always_comb begin
		cmd_in.is_start  = (item.action == lfw_pkg::ACTION_START);
		cmd_in.digits[0] = item.digit0;
		cmd_in.digits[1] = item.digit1;
		cmd_in.digits[2] = item.digit2;
		cmd_in.digits[3] = item.digit3;
		cmd_in.digits[4] = item.digit4;
	end

	assign item_stall = (count_q == lfw_pkg::QUEUE_CNT_W'(lfw_pkg::QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lfw_pkg::QUEUE_CNT_W'(lfw_pkg::QUEUE_DEPTH))
		else $error("command queue count exceeds its depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a lone push");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not follow a lone pop");
`endif

endmodule

### hdl/lfw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfw_back: frame sequencer of the frame writer
// Executes one queued command per cycle unless stalled, steps the pin levels
// through the frame segments and holds each result in an output register.
// ----------------------------------------------------------------------------
module lfw_back #(
	parameter int DIGIT_COUNT = lfw_pkg::DIGIT_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lfw_pkg::qhead_t  head,
	output logic             pop,
	input  logic             cfg_valid,
	input  logic [7:0]       cfg_data,
	output logic             result_valid,
	input  logic             result_stall,
	output lfw_pkg::result_t result
);

	localparam int SEG_BASE  = 7 + 2 * DIGIT_COUNT;
	localparam int SEG_TOTAL = SEG_BASE + 5;
	localparam int SW        = lfw_pkg::SEG_W;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;
	localparam logic [1:0] KIND_STOP  = 2'd3;

	function automatic logic [1:0] seg_kind(input logic [SW-1:0] s);
		logic [1:0] k;
		if (s < SW'(7)) begin
			case (s[2:0])
				3'd0, 3'd4: k = KIND_START;
				3'd1, 3'd5: k = KIND_BYTE;
				3'd2, 3'd6: k = KIND_ACK;
				default:    k = KIND_STOP;
			endcase
		end else if (s < SW'(SEG_BASE)) begin
			// Digit bytes sit on odd segment numbers, their acks on even ones.
			k = s[0] ? KIND_BYTE : KIND_ACK;
		end else if (s == SW'(SEG_BASE) || s == SW'(SEG_BASE + 4)) begin
			k = KIND_STOP;
		end else if (s == SW'(SEG_BASE + 1)) begin
			k = KIND_START;
		end else if (s == SW'(SEG_BASE + 2)) begin
			k = KIND_BYTE;
		end else begin
			k = KIND_ACK;
		end
		return k;
	endfunction

	logic [7:0]                 display_cmd_q;
	logic [7:0]                 digits_q [lfw_pkg::DIGIT_INPUTS];
	logic [SW-1:0]              seg_q;
	logic [1:0]                 phase_q;
	logic [2:0]                 bit_q;
	logic [7:0]                 shift_q;
	logic                       busy_q;
	logic                       scl_q;
	logic                       sda_q;
	logic                       res_valid_q;
	lfw_pkg::result_t           res_q;

	logic [SW-1:0]              seg_n;
	logic [1:0]                 phase_n;
	logic [2:0]                 bit_n;
	logic [7:0]                 shift_n;
	logic                       busy_n;
	logic                       scl_n;
	logic                       sda_n;
	logic                       done_n;
	logic                       last;
	logic                       hold;
	logic                       load_digits;
	logic [SW-1:0]              seg_inc;
	logic [SW-1:0]              digit_pos;
	logic [7:0]                 next_byte;
	lfw_pkg::result_t           res_n;

	assign pop     = head.valid && (!res_valid_q || !result_stall);
	assign seg_inc = seg_q + 1'b1;

	// Byte that the following segment will shift out.
	always_comb begin
		digit_pos = (seg_inc - SW'(7)) >> 1;
		if (seg_inc == SW'(1)) begin
			next_byte = lfw_pkg::CMD_DATA;
		end else if (seg_inc == SW'(5)) begin
			next_byte = lfw_pkg::CMD_ADDR;
		end else if (seg_inc >= SW'(7) && seg_inc < SW'(SEG_BASE)) begin
			if (digit_pos < SW'(lfw_pkg::DIGIT_INPUTS)) begin
				next_byte = digits_q[digit_pos[lfw_pkg::DIGIT_IDX_W-1:0]];
			end else begin
				next_byte = '0;
			end
		end else begin
			next_byte = display_cmd_q;
		end
	end

	always_comb begin
		seg_n       = seg_q;
		phase_n     = phase_q;
		bit_n       = bit_q;
		shift_n     = shift_q;
		busy_n      = busy_q;
		scl_n       = scl_q;
		sda_n       = sda_q;
		done_n      = 1'b0;
		last        = 1'b0;
		hold        = 1'b0;
		load_digits = 1'b0;
		if (pop) begin
			if (head.cmd.is_start) begin
				// A start during a frame is dropped.
				if (!busy_q) begin
					load_digits = 1'b1;
					busy_n      = 1'b1;
					seg_n       = '0;
					phase_n     = '0;
					bit_n       = '0;
				end
			end else if (busy_q) begin
				case (seg_kind(seg_q))
					KIND_START: begin
						if (phase_q == 2'd0) begin
							scl_n = 1'b1;
							sda_n = 1'b1;
						end else begin
							sda_n = 1'b0;
							last  = 1'b1;
						end
					end
					KIND_BYTE: begin
						if (phase_q == 2'd0) begin
							scl_n = 1'b0;
						end else if (phase_q == 2'd1) begin
							sda_n   = |(shift_q & lfw_pkg::LSB_MASK);
							shift_n = shift_q >> 1;
						end else begin
							scl_n = 1'b1;
							if (bit_q == 3'd7) begin
								last = 1'b1;
							end else begin
								bit_n = bit_q + 3'd1;
								hold  = 1'b1;
							end
						end
					end
					KIND_ACK: begin
						if (phase_q == 2'd0) begin
							scl_n = 1'b0;
						end else if (phase_q == 2'd1) begin
							scl_n = 1'b1;
						end else begin
							scl_n = 1'b0;
							last  = 1'b1;
						end
					end
					default: begin
						if (phase_q == 2'd0) begin
							scl_n = 1'b0;
						end else if (phase_q == 2'd1) begin
							sda_n = 1'b0;
						end else if (phase_q == 2'd2) begin
							scl_n = 1'b1;
						end else begin
							sda_n = 1'b1;
							last  = 1'b1;
						end
					end
				endcase
				if (last) begin
					phase_n = '0;
					bit_n   = '0;
					if (seg_inc == SW'(SEG_TOTAL)) begin
						seg_n  = '0;
						busy_n = 1'b0;
						done_n = 1'b1;
					end else begin
						seg_n = seg_inc;
						if (seg_kind(seg_inc) == KIND_BYTE) begin
							shift_n = next_byte;
						end
					end
				end else if (hold) begin
					phase_n = '0;
				end else begin
					phase_n = phase_q + 2'd1;
				end
			end
		end
		res_n.clock_pin  = scl_n;
		res_n.data_pin   = sda_n;
		res_n.data_drive = !(busy_n && (seg_kind(seg_n) == KIND_ACK));
		res_n.busy_res   = busy_n;
		res_n.frame_done = done_n;
	end

	always_ff @(posedge clk) begin
		if (load_digits) begin
			for (int i = 0; i < lfw_pkg::DIGIT_INPUTS; i++) begin
				digits_q[i] <= head.cmd.digits[i];
			end
		end
		if (pop) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_cmd_q <= lfw_pkg::CMD_DISP_RESET;
			seg_q         <= '0;
			phase_q       <= '0;
			bit_q         <= '0;
			shift_q       <= '0;
			busy_q        <= 1'b0;
			scl_q         <= 1'b1;
			sda_q         <= 1'b1;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				display_cmd_q <= cfg_data;
			end
			seg_q   <= seg_n;
			phase_q <= phase_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			busy_q  <= busy_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef ASSERT_OFF
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (seg_q == '0 && phase_q == '0 && bit_q == '0))
		else $error("sequencer counters not cleared while idle");

	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seg_q < SW'(SEG_TOTAL))
		else $error("segment index beyond the frame");

	a_done_on_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (res_valid_q && res_q.frame_done && !res_q.busy_res))
		else $error("frame ended without a done result");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LED driver frame writer
// Sends start and tick items over the stall handshake and predicts the pin
// levels of every step in a local model of the frame sequencer. Each result
// transfer is compared field by field with the oldest prediction. Phases
// change the display command between frames. Both sides idle at random
// except in the last phase.
// ----------------------------------------------------------------------------
module tb;

	localparam int DIGIT_COUNT = lfw_pkg::DIGIT_COUNT_DEF;
	localparam int BODY_END    = 7 + 2 * DIGIT_COUNT;
	localparam int SEG_TOTAL   = BODY_END + 5;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 150;
	localparam int DRAIN_WAIT  = 4;

	typedef enum logic [1:0] {SEG_START, SEG_BYTE, SEG_ACK, SEG_STOP} seg_kind_t;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	lfw_pkg::item_t   item;
	logic             result_valid;
	logic             result_stall;
	lfw_pkg::result_t result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [7:0]       cfg_data;

	// Local model of the frame sequencer.
	logic [4:0] seg_pos;
	logic [1:0] pin_step;
	logic [2:0] bit_pos;
	logic [7:0] shift_reg;
	logic [7:0] digit_latch [lfw_pkg::DIGIT_INPUTS];
	logic       frame_busy;
	logic       scl_level;
	logic       sda_level;
	logic [7:0] display_cmd;

	lfw_pkg::result_t expected_pins[$];
	int      errors;
	int      cycle_count;
	int      stall_left;
	bit      gaps_on;

	led_driver_frame_writer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic seg_kind_t kind_of(int s);
		if (s < 7) begin
			case (s)
				0, 4: return SEG_START;
				1, 5: return SEG_BYTE;
				3: return SEG_STOP;
				default: return SEG_ACK;
			endcase
		end
		if (s < BODY_END) return ((s - 7) % 2 == 1) ? SEG_ACK : SEG_BYTE;
		if (s == BODY_END || s == BODY_END + 4) return SEG_STOP;
		if (s == BODY_END + 1) return SEG_START;
		if (s == BODY_END + 2) return SEG_BYTE;
		return SEG_ACK;
	endfunction

	function automatic logic [7:0] byte_of(int s);
		int d;
		if (s == 1) return lfw_pkg::CMD_DATA;
		if (s == 5) return lfw_pkg::CMD_ADDR;
		if (s >= 7 && s < BODY_END) begin
			d = (s - 7) / 2;
			return (d < lfw_pkg::DIGIT_INPUTS) ? digit_latch[d] : 8'h00;
		end
		return display_cmd;
	endfunction

	// Applies one item to the local model and returns the pins it leaves.
	function automatic lfw_pkg::result_t advance_frame(lfw_pkg::item_t it);
		lfw_pkg::result_t r;
		logic    last;
		logic    bump;
		logic    done;
		last = 1'b0;
		bump = 1'b1;
		done = 1'b0;
		if (it.action == lfw_pkg::ACTION_START) begin
			if (!frame_busy) begin
				digit_latch[0] = it.digit0;
				digit_latch[1] = it.digit1;
				digit_latch[2] = it.digit2;
				digit_latch[3] = it.digit3;
				digit_latch[4] = it.digit4;
				frame_busy = 1'b1;
				seg_pos = '0;
				pin_step = '0;
				bit_pos = '0;
			end
		end else if (frame_busy) begin
			case (kind_of(seg_pos))
				SEG_START: begin
					if (pin_step == 0) begin
						scl_level = 1'b1;
						sda_level = 1'b1;
					end else begin
						sda_level = 1'b0;
						last = 1'b1;
					end
				end
				SEG_BYTE: begin
					if (pin_step == 0) begin
						scl_level = 1'b0;
					end else if (pin_step == 1) begin
						sda_level = shift_reg[0];
						shift_reg = shift_reg >> 1;
					end else begin
						scl_level = 1'b1;
						if (bit_pos == 3'd7) begin
							last = 1'b1;
						end else begin
							bit_pos = bit_pos + 1'b1;
							pin_step = '0;
							bump = 1'b0;
						end
					end
				end
				SEG_ACK: begin
					if (pin_step == 0) scl_level = 1'b0;
					else if (pin_step == 1) scl_level = 1'b1;
					else begin
						scl_level = 1'b0;
						last = 1'b1;
					end
				end
				default: begin
					if (pin_step == 0) scl_level = 1'b0;
					else if (pin_step == 1) sda_level = 1'b0;
					else if (pin_step == 2) scl_level = 1'b1;
					else begin
						sda_level = 1'b1;
						last = 1'b1;
					end
				end
			endcase
			if (last) begin
				pin_step = '0;
				bit_pos = '0;
				seg_pos = seg_pos + 1'b1;
				if (seg_pos >= SEG_TOTAL) begin
					seg_pos = '0;
					frame_busy = 1'b0;
					done = 1'b1;
				end else if (kind_of(seg_pos) == SEG_BYTE) begin
					shift_reg = byte_of(seg_pos);
				end
			end else if (bump) begin
				pin_step = pin_step + 1'b1;
			end
		end
		r.clock_pin  = scl_level;
		r.data_pin   = sda_level;
		r.data_drive = (frame_busy && kind_of(seg_pos) == SEG_ACK) ? 1'b0 : 1'b1;
		r.busy_res   = frame_busy;
		r.frame_done = done;
		return r;
	endfunction

	function automatic logic [7:0] random_digit();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic lfw_pkg::item_t make_item(logic start);
		lfw_pkg::item_t it;
		it.action = start ? lfw_pkg::ACTION_START : lfw_pkg::ACTION_TICK;
		it.digit0 = random_digit();
		it.digit1 = random_digit();
		it.digit2 = random_digit();
		it.digit3 = random_digit();
		it.digit4 = random_digit();
		return it;
	endfunction

	task automatic send_item(lfw_pkg::item_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		expected_pins.push_back(advance_frame(it));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (expected_pins.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_display_command(logic [7:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		display_cmd = value;
	endtask

	task automatic compare_field(string name, logic want, logic got);
		if (want !== got) begin
			$display("%0t: %s expected %b actual %b", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result(lfw_pkg::result_t got);
		lfw_pkg::result_t want;
		if (expected_pins.size() == 0) begin
			$display("%0t: result %b with none expected", $time, got);
			errors++;
		end else begin
			want = expected_pins.pop_front();
			compare_field("clock_pin", want.clock_pin, got.clock_pin);
			compare_field("data_pin", want.data_pin, got.data_pin);
			compare_field("data_drive", want.data_drive, got.data_drive);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("frame_done", want.frame_done, got.frame_done);
		end
	endtask

	// Ticks with no frame in progress leave the pins at their reset levels.
	task automatic test_idle_ticks();
		send_item(make_item(1'b0));
		send_item(make_item(1'b0));
	endtask

	// A start with extreme digits, then starts that arrive mid-frame.
	task automatic test_start_while_busy();
		lfw_pkg::item_t it;
		it = '{action: lfw_pkg::ACTION_START, digit0: 8'hFF, digit1: 8'h00,
			digit2: 8'hAA, digit3: 8'h55, digit4: 8'h01};
		send_item(it);
		it = '{action: lfw_pkg::ACTION_START, digit0: 8'h00, digit1: 8'hFF,
			digit2: 8'h55, digit3: 8'hAA, digit4: 8'h80};
		send_item(it);
		repeat (9) send_item(make_item(1'b0));
		send_item(make_item(1'b1));
		repeat (9) send_item(make_item(1'b0));
	endtask

	// Random frames; a phase always runs its last frame to completion.
	task automatic test_random_frames(int count);
		logic start;
		for (int i = 0; i < count; i++) begin
			if (!frame_busy) start = ($urandom_range(0, 3) != 0);
			else start = ($urandom_range(0, 39) == 0);
			send_item(make_item(start));
		end
		while (frame_busy) send_item(make_item(1'b0));
	endtask

	always @(posedge clk) begin
		if (result_valid && !result_stall) check_result(result);
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 16);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		result_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		errors = 0;
		cycle_count = 0;
		stall_left = 0;
		gaps_on = 1'b1;
		seg_pos = '0;
		pin_step = '0;
		bit_pos = '0;
		shift_reg = '0;
		for (int i = 0; i < lfw_pkg::DIGIT_INPUTS; i++) digit_latch[i] = '0;
		frame_busy = 1'b0;
		scl_level = 1'b1;
		sda_level = 1'b1;
		display_cmd = lfw_pkg::CMD_DISP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_ticks();
		test_start_while_busy();
		test_random_frames(PHASE_ITEMS);
		write_display_command(8'h00);
		test_random_frames(PHASE_ITEMS);
		write_display_command(8'hFF);
		test_random_frames(PHASE_ITEMS);
		write_display_command(8'($urandom));
		test_random_frames(PHASE_ITEMS);
		write_display_command(8'($urandom));
		gaps_on = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		test_random_frames(PHASE_ITEMS);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && expected_pins.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
